@@ src/cst_pkg.sv @@
// Package: payload types, codes and sizes for the clique slack tracker.
`default_nettype none
package cst_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned ROW_WORDS    = 16;
  localparam int unsigned VW           = 10;   // vertex id width
  localparam int unsigned CW           = 11;   // count / slack width
  localparam int unsigned CADDR_W      = 14;   // complement row store address
  localparam logic [CW-1:0] N_LIMIT    = 11'd1024;
  localparam logic [CW-1:0] VC_RESET   = 11'd1024;

  localparam logic [63:0] MIX_A = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_B = 64'hbf58476d1ce4e5b9;

  localparam logic [2:0] MODE_LOAD  = 3'd0;
  localparam logic [2:0] MODE_ADD   = 3'd1;
  localparam logic [2:0] MODE_DROP  = 3'd2;
  localparam logic [2:0] MODE_SWAP  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_REJ   = 2'd1;
  localparam logic [1:0] ST_NOBLK = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  vertex;
    logic [3:0]  word_index;
    logic [63:0] row_word;
    logic        nbr_free;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] clique_size;
    logic [10:0] addable_count;
    logic [10:0] swappable_count;
    logic [63:0] clique_hash;
    logic [9:0]  blocker_vertex;
    logic        vertex_allowed;
  } out_word_t;

  typedef struct packed {
    logic          in_c;
    logic          allow;
    logic [CW-1:0] slack;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHK, S_VRD, S_VUPD, S_MIX, S_WALK, S_SCAN, S_FIN
  } state_e;

endpackage
`default_nettype wire

@@ src/cst_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module cst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/clique_slack_tracker_top.sv @@
// Top level: clique slack tracker, sequencer over row store and vertex state RAM.
//
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one command word at a
// time; the block is not ready while a word is being worked on. Each word gives
// exactly one result word on out_valid_o/out_ready_i/out_data_o, held in an
// output register; a new word may be taken while a result waits there.
// Config channel (cfg_valid_i/cfg_ready_o) writes vertex_count; it is ready only
// while the block is idle, holds off input words in that cycle and starts a clear.
// Work per word, n = vertex count in use:
//   load and rejected words: a vertex check, then the result.
//   add or drop: one row walk, one vertex a cycle, plus a hash mix on the
//   single shared 32x32 multiplier.
//   swap: blocker scan over up to n vertices, then a drop and an add.
//   clear: the clearing pass over the 1024-entry vertex RAM.
// After reset and after every config write the same clearing pass runs,
// during which no word is accepted. When the receiver stalls, a
// finished result waits in the output register and the block holds before
// writing the next one.
`default_nettype none
module clique_slack_tracker_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cst_pkg::in_word_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cst_pkg::out_word_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [10:0]       cfg_data_i
);
  import cst_pkg::*;

  state_e state_q, state_d;

  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] cnt_q, cnt_d, add_q, add_d, swp_q, swp_d;
  logic [63:0]   hash_q, hash_d;
  logic [VW-1:0] clr_q, clr_d;
  logic          clr_item_q, clr_item_d;

  logic [VW-1:0] v_q, v_d, tgt_q, tgt_d, blk_q, blk_d;
  logic [2:0]    mode_q, mode_d;
  logic          free_q, free_d, op_add_q, op_add_d, swp_ph_q, swp_ph_d;
  logic [1:0]    status_q, status_d;
  logic          allowed_q, allowed_d;

  logic [VW-1:0] rd_u_q, rd_u_d, pu_q, pu_d;
  logic          rd_act_q, rd_act_d, pv_q, pv_d;

  logic [3:0]    mcnt_q, mcnt_d;
  logic [63:0]   mx_q, mx_d, acc_q, acc_d, prod_q, prod_d;

  logic          out_valid_q, out_valid_d;
  out_word_t     out_q, out_d;

  // RAM ports
  logic               ent_we;
  logic [VW-1:0]      ent_waddr, ent_raddr;
  entry_t             ent_wdata, ent_rdata;
  logic               cmp_we;
  logic [CADDR_W-1:0] cmp_waddr, cmp_raddr;
  logic [63:0]        cmp_wdata, cmp_rdata;

  cst_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_VERTICES)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wdata),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  cst_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES * ROW_WORDS)) u_cmp_ram (
    .clk_i, .we_i(cmp_we), .waddr_i(cmp_waddr), .wdata_i(cmp_wdata),
    .raddr_i(cmp_raddr), .rdata_o(cmp_rdata)
  );

  function automatic logic is_add(entry_t e);
    return !e.in_c && (e.slack == '0);
  endfunction

  function automatic logic is_swp(entry_t e);
    return !e.in_c && (e.slack == CW'(1));
  endfunction

  function automatic logic [CW-1:0] clamp_n(logic [10:0] vc);
    if (vc == '0) return CW'(1);
    if (vc > N_LIMIT) return N_LIMIT;
    return vc;
  endfunction

  // shared 32x32 multiplier
  logic [3:0]  mk;
  logic [63:0] mb;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, acc_fin, mix_x;
  logic [VW-1:0] last_u;
  logic        accept, nonadj;
  entry_t      ent_new;
  logic        cnt_en;
  entry_t      cnt_old;

  assign mk     = (mcnt_q < 4'd5) ? mcnt_q : mcnt_q - 4'd5;
  assign mb     = (mcnt_q < 4'd5) ? MIX_A : MIX_B;
  assign mul_a  = (mk == 4'd1) ? mx_q[63:32] : mx_q[31:0];
  assign mul_b  = (mk == 4'd2) ? mb[63:32] : mb[31:0];
  assign mul_p  = 64'(mul_a) * 64'(mul_b);
  assign acc_fin = acc_q;
  assign mix_x  = (mcnt_q < 4'd5) ? (acc_fin ^ (acc_fin >> 29)) : (acc_fin ^ (acc_fin >> 32));

  assign last_u = VW'(n_q - CW'(1));
  assign accept = in_valid_i && in_ready_o;
  assign nonadj = cmp_rdata[pu_q[5:0]];

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    n_d = n_q; cnt_d = cnt_q; add_d = add_q; swp_d = swp_q; hash_d = hash_q;
    clr_d = clr_q; clr_item_d = clr_item_q;
    v_d = v_q; tgt_d = tgt_q; blk_d = blk_q; mode_d = mode_q; free_d = free_q;
    op_add_d = op_add_q; swp_ph_d = swp_ph_q; status_d = status_q;
    allowed_d = allowed_q;
    rd_u_d = rd_u_q; pu_d = pu_q; rd_act_d = rd_act_q; pv_d = pv_q;
    mcnt_d = mcnt_q; mx_d = mx_q; acc_d = acc_q; prod_d = prod_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;

    ent_we = 1'b0; ent_waddr = tgt_q; ent_wdata = ent_rdata;
    ent_raddr = tgt_q;
    cmp_we = 1'b0;
    cmp_waddr = {in_data_i.vertex, in_data_i.word_index};
    cmp_wdata = in_data_i.row_word;
    cmp_raddr = {(state_q == S_SCAN) ? v_q : tgt_q, rd_u_q[9:6]};
    ent_new = ent_rdata;
    cnt_en = 1'b0;
    cnt_old = ent_rdata;

    // streaming read of one row, one vertex a cycle
    if (state_q == S_WALK || state_q == S_SCAN) begin
      ent_raddr = rd_u_q;
      pv_d = rd_act_q;
      pu_d = rd_u_q;
      if (rd_act_q) begin
        rd_u_d = rd_u_q + VW'(1);
        if (rd_u_q == last_u) rd_act_d = 1'b0;
      end
    end

    case (state_q)
      S_CLEAR: begin
        ent_we = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '{in_c: 1'b0, allow: 1'b1, slack: '0};
        clr_d = clr_q + VW'(1);
        if (clr_q == VW'(MAX_VERTICES - 1)) begin
          if (clr_item_q) begin
            status_d = ST_OK; blk_d = '0; allowed_d = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_IDLE;
          end
          clr_item_d = 1'b0;
        end
      end
      S_IDLE: begin
        ent_raddr = in_data_i.vertex;
        if (accept) begin
          v_d = in_data_i.vertex; mode_d = in_data_i.mode;
          free_d = in_data_i.nbr_free; blk_d = '0; status_d = ST_OK;
          swp_ph_d = 1'b0;
          state_d = S_CHK;
          if (in_data_i.mode == MODE_LOAD) begin
            if (5'(in_data_i.word_index) >= 5'(ROW_WORDS)) begin
              status_d = ST_REJ;
            end else begin
              cmp_we = 1'b1;
              if (in_data_i.vertex[9:6] == in_data_i.word_index)
                cmp_wdata[in_data_i.vertex[5:0]] = 1'b0;
            end
          end else if (in_data_i.mode == MODE_CLEAR) begin
            cnt_d = '0; add_d = n_q; swp_d = '0; hash_d = '0;
            clr_d = '0; clr_item_d = 1'b1;
            state_d = S_CLEAR;
          end
        end
      end
      S_CHK: begin
        allowed_d = ent_rdata.allow;
        tgt_d = v_q;
        state_d = S_FIN;
        case (mode_q)
          MODE_LOAD: ;
          MODE_ADD: begin
            if ({1'b0, v_q} >= n_q || ent_rdata.in_c) status_d = ST_REJ;
            else begin op_add_d = 1'b1; state_d = S_VRD; end
          end
          MODE_DROP: begin
            if ({1'b0, v_q} >= n_q || !ent_rdata.in_c) status_d = ST_REJ;
            else begin op_add_d = 1'b0; allowed_d = 1'b0; state_d = S_VRD; end
          end
          MODE_SWAP: begin
            if ({1'b0, v_q} >= n_q || ent_rdata.in_c) status_d = ST_REJ;
            else begin
              rd_u_d = '0; rd_act_d = 1'b1; pv_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          default: status_d = ST_REJ;
        endcase
      end
      S_SCAN: begin
        if (pv_q && ent_rdata.in_c && nonadj) begin
          blk_d = pu_q; tgt_d = pu_q; op_add_d = 1'b0; swp_ph_d = 1'b1;
          state_d = S_VRD;
        end else if (pv_q && pu_q == last_u) begin
          status_d = ST_NOBLK;
          state_d = S_FIN;
        end
      end
      S_VRD: state_d = S_VUPD;
      S_VUPD: begin
        if (op_add_q) begin
          ent_new.in_c = 1'b1;
          ent_new.slack = ent_rdata.slack + CW'(1);
          cnt_d = cnt_q + CW'(1);
        end else begin
          ent_new.in_c = 1'b0;
          ent_new.allow = 1'b0;
          ent_new.slack = ent_rdata.slack - CW'(1);
          cnt_d = cnt_q - CW'(1);
        end
        cnt_en = 1'b1;
        ent_we = 1'b1; ent_waddr = tgt_q; ent_wdata = ent_new;
        mx_d = 64'(tgt_q) + 64'd1;
        mcnt_d = '0;
        state_d = S_MIX;
      end
      S_MIX: begin
        prod_d = mul_p;
        mcnt_d = mcnt_q + 4'd1;
        case (mk)
          4'd0: ;
          4'd1: acc_d = prod_q;
          4'd2: acc_d = acc_q + {prod_q[31:0], 32'd0};
          4'd3: acc_d = acc_q + {prod_q[31:0], 32'd0};
          default: mx_d = mix_x;
        endcase
        if (mcnt_q == 4'd9) begin
          hash_d = hash_q ^ mix_x;
          rd_u_d = '0; rd_act_d = 1'b1; pv_d = 1'b0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (pv_q) begin
          ent_waddr = pu_q;
          if (nonadj) begin
            ent_new.slack = op_add_q ? ent_rdata.slack + CW'(1) : ent_rdata.slack - CW'(1);
            ent_we = 1'b1; cnt_en = 1'b1;
          end else if (op_add_q && free_q && pu_q != tgt_q) begin
            ent_new.allow = 1'b1;
            ent_we = 1'b1;
          end
          ent_wdata = ent_new;
          if (pu_q == last_u) begin
            if (swp_ph_q) begin
              swp_ph_d = 1'b0; tgt_d = v_q; op_add_d = 1'b1;
              state_d = S_VRD;
            end else begin
              state_d = S_FIN;
            end
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d = '{status: status_q, clique_size: cnt_q, addable_count: add_q,
                    swappable_count: swp_q, clique_hash: hash_q,
                    blocker_vertex: blk_q, vertex_allowed: allowed_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cnt_en) begin
      add_d = add_q + CW'(is_add(ent_new)) - CW'(is_add(cnt_old));
      swp_d = swp_q + CW'(is_swp(ent_new)) - CW'(is_swp(cnt_old));
    end

    // config write: new vertex count and a full clear
    if (cfg_valid_i && cfg_ready_o) begin
      n_d = clamp_n(cfg_data_i);
      cnt_d = '0; add_d = clamp_n(cfg_data_i); swp_d = '0; hash_d = '0;
      clr_d = '0; clr_item_d = 1'b0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      n_q <= clamp_n(VC_RESET);
      cnt_q <= '0; add_q <= clamp_n(VC_RESET); swp_q <= '0; hash_q <= '0;
      clr_q <= '0; clr_item_q <= 1'b0;
      rd_act_q <= 1'b0; pv_q <= 1'b0; mcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q <= n_d;
      cnt_q <= cnt_d; add_q <= add_d; swp_q <= swp_d; hash_q <= hash_d;
      clr_q <= clr_d; clr_item_q <= clr_item_d;
      rd_act_q <= rd_act_d; pv_q <= pv_d; mcnt_q <= mcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; tgt_q <= tgt_d; blk_q <= blk_d; mode_q <= mode_d; free_q <= free_d;
    op_add_q <= op_add_d; swp_ph_q <= swp_ph_d; status_q <= status_d;
    allowed_q <= allowed_d;
    rd_u_q <= rd_u_d; pu_q <= pu_d;
    mx_q <= mx_d; acc_q <= acc_d; prod_q <= prod_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire

@@ src/cst_checker.sv @@
// Port-level checker for the clique slack tracker, bound to the top level.
`default_nettype none
module cst_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire cst_pkg::out_word_t out_data_o
);
  import cst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready again right after a word was taken");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined status code");

  a_blocker_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.blocker_vertex != '0 |-> out_data_o.status == ST_OK)
    else $error("blocker reported without a completed swap");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.clique_size <= N_LIMIT)
    else $error("clique size beyond vertex limit");

endmodule

bind clique_slack_tracker_top cst_checker u_cst_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire

@@ tb/cst_checker.sv @@
// Checker: watches the tracker channels, predicts each result word and compares.
module cst_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  cst_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  cst_pkg::out_word_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [10:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  logic [63:0] rows [MAX_VERTICES*ROW_WORDS];
  logic [10:0] slack [MAX_VERTICES];
  bit          member [MAX_VERTICES];
  bit          allow [MAX_VERTICES];
  logic [10:0] size_q, addable_q, swappable_q, vcount_q;
  logic [63:0] hash_q;
  out_word_t   expected_words [$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = expected_words.size();

  function automatic int unsigned n_active();
    if (vcount_q < 1) return 1;
    if (vcount_q > N_LIMIT) return N_LIMIT;
    return vcount_q;
  endfunction

  function automatic logic [63:0] mix_id(int unsigned v);
    logic [63:0] x;
    x = (64'(v) + 64'd1) * MIX_A;
    x ^= x >> 29;
    x = x * MIX_B;
    x ^= x >> 32;
    return x;
  endfunction

  function automatic bit apart(int unsigned v, int unsigned u);
    return rows[v*ROW_WORDS + (u >> 6)][u & 63];
  endfunction

  // 0 addable, 1 swappable, 2 neither
  function automatic int kind(int unsigned v);
    if (member[v]) return 2;
    if (slack[v] == 0) return 0;
    if (slack[v] == 1) return 1;
    return 2;
  endfunction

  task automatic tally(int unsigned v, bit plus);
    int k;
    k = kind(v);
    if (k == 0) addable_q = plus ? addable_q + 11'd1 : addable_q - 11'd1;
    else if (k == 1) swappable_q = plus ? swappable_q + 11'd1 : swappable_q - 11'd1;
  endtask

  task automatic bump_slack(int unsigned v, bit up);
    tally(v, 0);
    slack[v] = up ? slack[v] + 11'd1 : slack[v] - 11'd1;
    tally(v, 1);
  endtask

  task automatic clear_clique();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      member[i] = 0;
      slack[i]  = '0;
      allow[i]  = 1;
    end
    size_q      = '0;
    hash_q      = '0;
    addable_q   = 11'(n_active());
    swappable_q = '0;
  endtask

  task automatic join_clique(int unsigned v, bit free_nb, int unsigned n);
    tally(v, 0);
    member[v] = 1;
    size_q++;
    hash_q ^= mix_id(v);
    slack[v] = slack[v] + 11'd1;
    tally(v, 1);
    for (int unsigned u = 0; u < n; u++)
      if (apart(v, u)) bump_slack(u, 1);
    if (free_nb)
      for (int unsigned u = 0; u < n; u++)
        if (u != v && !apart(v, u)) allow[u] = 1;
  endtask

  task automatic leave_clique(int unsigned v, int unsigned n);
    tally(v, 0);
    member[v] = 0;
    size_q--;
    allow[v] = 0;
    hash_q ^= mix_id(v);
    slack[v] = slack[v] - 11'd1;
    tally(v, 1);
    for (int unsigned u = 0; u < n; u++)
      if (apart(v, u)) bump_slack(u, 0);
  endtask

  task automatic predict_word(input in_word_t w, output out_word_t r);
    int unsigned v, n, blk;
    logic [63:0] word;
    logic [1:0]  st;
    bit          found;
    v = w.vertex;
    n = n_active();
    blk = 0;
    st = ST_OK;
    found = 0;
    word = w.row_word;
    case (w.mode)
      MODE_LOAD: begin
        if ((v >> 6) == w.word_index) word[v & 63] = 1'b0;
        rows[v*ROW_WORDS + w.word_index] = word;
      end
      MODE_ADD: begin
        if (v >= n || member[v]) st = ST_REJ;
        else join_clique(v, w.nbr_free, n);
      end
      MODE_DROP: begin
        if (v >= n || !member[v]) st = ST_REJ;
        else leave_clique(v, n);
      end
      MODE_SWAP: begin
        if (v >= n || member[v]) st = ST_REJ;
        else begin
          for (int unsigned u = 0; u < n && !found; u++)
            if (member[u] && apart(v, u)) begin
              found = 1;
              blk = u;
            end
          if (!found) st = ST_NOBLK;
          else begin
            leave_clique(blk, n);
            join_clique(v, w.nbr_free, n);
          end
        end
      end
      MODE_CLEAR: clear_clique();
      default: st = ST_REJ;
    endcase
    r.status          = st;
    r.clique_size     = size_q;
    r.addable_count   = addable_q;
    r.swappable_count = swappable_q;
    r.clique_hash     = hash_q;
    r.blocker_vertex  = 10'(blk);
    r.vertex_allowed  = allow[v];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t r, e;
    if (!rst_ni) begin
      vcount_q = VC_RESET;
      clear_clique();
      expected_words.delete();
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        vcount_q = cfg_data_i;
        clear_clique();
      end
      if (in_valid_i && in_ready_i) begin
        predict_word(in_data_i, r);
        expected_words = {expected_words, r};
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %p", out_data_i);
        end else begin
          e = expected_words.pop_front();
          if (out_data_i.status !== e.status ||
              out_data_i.clique_size !== e.clique_size ||
              out_data_i.addable_count !== e.addable_count ||
              out_data_i.swappable_count !== e.swappable_count ||
              out_data_i.clique_hash !== e.clique_hash ||
              out_data_i.blocker_vertex !== e.blocker_vertex ||
              out_data_i.vertex_allowed !== e.vertex_allowed) begin
            errors++;
            if (errors <= 10)
              $display("mismatch at %0t: expected %p got %p", $realtime, e, out_data_i);
          end
        end
      end
    end
  end

endmodule

@@ tb/clique_slack_tracker_top_test.sv @@
// Testbench top: stimulus, handshakes and verdict for the clique slack tracker.
module clique_slack_tracker_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cst_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_word_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  int          errors, pending;
  bit          quiet = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit [15:0]   loaded [MAX_VERTICES];
  int unsigned pool [$];
  int unsigned n_now, words_now;

  localparam int IDLE_LIMIT = 20000;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  clique_slack_tracker_top dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  cst_scoreboard chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (quiet) out_ready <= 1;
    else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 0;
    end else out_ready <= 1;
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("clique_slack_tracker_top regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [63:0] row_bits();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(in_word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_data  <= w;
    in_valid <= 1;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
    if (w.mode == MODE_LOAD) loaded[w.vertex][w.word_index] = 1;
  endtask

  task automatic load_word(int unsigned v, int unsigned wi);
    in_word_t w;
    w = '{mode: MODE_LOAD, vertex: 10'(v), word_index: 4'(wi),
          row_word: row_bits(), nbr_free: 1'($urandom)};
    send(w);
  endtask

  function automatic bit row_ready(int unsigned v);
    bit [15:0] need;
    need = 16'((32'd1 << words_now) - 1);
    return v >= n_now || (loaded[v] & need) == need;
  endfunction

  // vertex for a command that walks a row: stays inside the loaded rows
  function automatic int unsigned pick_vertex();
    int unsigned v;
    if ($urandom_range(0, 6) != 0) return pool[$urandom_range(0, pool.size() - 1)];
    v = $urandom_range(0, MAX_VERTICES - 1);
    return row_ready(v) ? v : pool[0];
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [10:0] vc, int items);
    in_word_t w;
    int unsigned ps, v;
    int r;
    wait_drained();
    cfg_data  <= vc;
    cfg_valid <= 1;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 0;
    n_now = (vc < 1) ? 1 : (vc > N_LIMIT) ? N_LIMIT : vc;
    words_now = ((n_now - 1) >> 6) + 1;
    ps = (words_now > 4) ? 4 : (n_now < 12) ? n_now : 12;
    pool.delete();
    pool = {pool, 0};
    if (n_now > 1) pool = {pool, n_now - 1};
    while (pool.size() < ps) pool = {pool, $urandom_range(1, n_now - 1)};
    foreach (pool[i])
      for (int unsigned wi = 0; wi < words_now; wi++)
        if (!loaded[pool[i]][wi] || $urandom_range(0, 1)) load_word(pool[i], wi);
    for (int i = 0; i < items; i++) begin
      w = '{mode: MODE_ADD, vertex: 10'(pick_vertex()),
            word_index: 4'($urandom), row_word: {$urandom, $urandom},
            nbr_free: 1'($urandom)};
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // reload a row word mid-clique, or any word anywhere
        v = $urandom_range(0, 1) ? pool[$urandom_range(0, pool.size() - 1)]
                                 : $urandom_range(0, MAX_VERTICES - 1);
        w.mode = MODE_LOAD;
        w.vertex = 10'(v);
        w.row_word = row_bits();
      end
      else if (r < 45) w.mode = MODE_ADD;
      else if (r < 70) w.mode = MODE_DROP;
      else if (r < 92) w.mode = MODE_SWAP;
      else if (r < 95) w.mode = MODE_CLEAR;
      else w.mode = 3'($urandom_range(5, 7));
      send(w);
    end
  endtask

  initial begin
    in_word_t w;
    foreach (loaded[i]) loaded[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    // directed: reset sizing, clear, unused modes, rejected drop, self-bit loads
    n_now = N_LIMIT;
    w = '{mode: MODE_CLEAR, vertex: 10'd1023, word_index: 4'd15,
          row_word: '1, nbr_free: 1'b1};
    send(w);
    for (int m = 5; m < 8; m++) begin
      w.mode = 3'(m);
      w.vertex = 10'($urandom);
      send(w);
    end
    w = '{mode: MODE_DROP, vertex: 10'd5, word_index: 4'd0,
          row_word: '0, nbr_free: 1'b0};
    send(w);
    w = '{mode: MODE_LOAD, vertex: 10'd1023, word_index: 4'd15,
          row_word: '1, nbr_free: 1'b0};
    send(w);
    w = '{mode: MODE_LOAD, vertex: 10'd0, word_index: 4'd0,
          row_word: '1, nbr_free: 1'b1};
    send(w);
    w = '{mode: MODE_LOAD, vertex: 10'd5, word_index: 4'd3,
          row_word: '0, nbr_free: 1'b0};
    send(w);

    run_phase(11'd40, 120);
    run_phase(11'd0, 20);
    run_phase(11'd64, 100);
    run_phase(11'd100, 70);
    run_phase(11'd2047, 30);
    run_phase(11'd1, 15);
    quiet = 1;
    run_phase(11'd13, 65);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("clique_slack_tracker_top regression: pass");
    else $display("clique_slack_tracker_top regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
src/cst_pkg.sv
src/cst_ram.sv
src/clique_slack_tracker_top.sv
src/cst_checker.sv
tb/cst_checker.sv
tb/clique_slack_tracker_top_test.sv
